// ----- src/salc_pkg.sv -----
// Shared constants for the set-associative LRU cache tag model.
// No dependencies; used by set_assoc_lru_cache_model.
package salc_pkg;

    // Fixed field widths
    localparam int ADDR_FIELD_W   = 64;
    localparam int TOTAL_W        = 32;
    localparam int SET_BITS_W     = 3;
    localparam int BLOCK_BITS_W   = 4;

    // Default geometry
    localparam int DEF_WAYS         = 4;
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_ADDR_WIDTH   = 64;

    // Block offset is saturated to this many bits
    localparam int MAX_BLOCK_BITS   = 12;

    // Reset values of the configuration registers
    localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
    localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 4'd4;

    // APB register map: register index is paddr[CFG_IDX_BIT]
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_BIT = 2;

    typedef enum logic [0:0] {
        CFG_SET_BITS   = 1'b0,
        CFG_BLOCK_BITS = 1'b1
    } t_cfg_idx;

endpackage

// ----- src/set_assoc_lru_cache_model.sv -----
// Set-associative cache tag model with exact LRU replacement, top level.
// Depends on salc_pkg (constants and register map).
//
// Usage:
//   Input channel: one word per access, i_address, handshake i_valid/o_stall.
//   Output channel: one word per access, hit/miss/evicted flags plus running
//   totals, handshake o_valid/i_stall. Every accepted address gives exactly
//   one result word, in order.
//   Config: APB-style, set_bits at byte address 0, block_bits at address 4.
//   Write only while no access is in flight.
//
// Timing:
//   The set row is read from the tag/rank memory at the accept edge into the
//   lookup stage registers; the lookup and LRU update run there and land in
//   the output register when the lookup stage advances, raising o_valid.
//   Throughput is one address per cycle while the receiver does not stall,
//   also when consecutive addresses hit the same set (the written row is
//   forwarded). When the receiver stalls, the output word holds, and o_stall
//   rises once the lookup stage holds an address (one more is taken if empty).
//
// Reset:
//   All lines invalid (per-line valid flops cleared at once, no clearing
//   pass), totals zero, set_bits = 4, block_bits = 4. Tag and rank memories
//   are not cleared; their contents are ignored until a line becomes valid.
module set_assoc_lru_cache_model #(
    parameter int WAYS         = salc_pkg::DEF_WAYS,
    parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // access input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [salc_pkg::ADDR_FIELD_W-1:0]   i_address,

    // result output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic                                o_miss,
    output logic                                o_evicted,
    output logic [salc_pkg::TOTAL_W-1:0]        o_hit_total,
    output logic [salc_pkg::TOTAL_W-1:0]        o_miss_total,
    output logic [salc_pkg::TOTAL_W-1:0]        o_evict_total,

    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [salc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [salc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    // smallest split is one set bit and one offset bit
    localparam int TAG_W    = ADDR_WIDTH - 2;
    localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_W    = RANK_W;
    localparam int SHAMT_W  = 5;
    localparam int TW       = salc_pkg::TOTAL_W;

    typedef logic [WAYS-1:0][TAG_W-1:0]  t_tag_row;
    typedef logic [WAYS-1:0][RANK_W-1:0] t_rank_row;

    // ---------------- configuration ----------------
    logic [salc_pkg::SET_BITS_W-1:0]   r_set_bits;
    logic [salc_pkg::BLOCK_BITS_W-1:0] r_block_bits;
    logic                              cfg_wr;
    salc_pkg::t_cfg_idx                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = salc_pkg::t_cfg_idx'(paddr[salc_pkg::CFG_IDX_BIT]);

    always_comb begin
        case (cfg_idx)
            salc_pkg::CFG_SET_BITS:
                prdata = {{(salc_pkg::CFG_DATA_W-salc_pkg::SET_BITS_W){1'b0}}, r_set_bits};
            salc_pkg::CFG_BLOCK_BITS:
                prdata = {{(salc_pkg::CFG_DATA_W-salc_pkg::BLOCK_BITS_W){1'b0}},
                          r_block_bits};
            default:
                prdata = '0;
        endcase
    end

    // Saturate the split to its legal range
    logic [salc_pkg::SET_BITS_W-1:0]   s_eff;
    logic [salc_pkg::BLOCK_BITS_W-1:0] b_eff;

    always_comb begin
        s_eff = r_set_bits;
        if (r_set_bits == '0)
            s_eff = salc_pkg::SET_BITS_W'(1);
        else if (int'(r_set_bits) > MAX_SET_BITS)
            s_eff = salc_pkg::SET_BITS_W'(MAX_SET_BITS);
        b_eff = r_block_bits;
        if (r_block_bits == '0)
            b_eff = salc_pkg::BLOCK_BITS_W'(1);
        else if (int'(r_block_bits) > salc_pkg::MAX_BLOCK_BITS)
            b_eff = salc_pkg::BLOCK_BITS_W'(salc_pkg::MAX_BLOCK_BITS);
    end

    // ---------------- address split at the input ----------------
    logic [ADDR_WIDTH-1:0]   in_addr;
    logic [ADDR_WIDTH-1:0]   in_off_shift;
    logic [MAX_SET_BITS-1:0] set_mask;
    logic [MAX_SET_BITS-1:0] in_set;
    logic [SHAMT_W-1:0]      tag_shamt;
    logic [TAG_W-1:0]        in_tag;

    assign in_addr      = i_address[ADDR_WIDTH-1:0];
    assign in_off_shift = in_addr >> b_eff;
    assign set_mask     = ~({MAX_SET_BITS{1'b1}} << s_eff);
    assign in_set       = in_off_shift[MAX_SET_BITS-1:0] & set_mask;
    assign tag_shamt    = {{(SHAMT_W-salc_pkg::SET_BITS_W){1'b0}}, s_eff}
                        + {{(SHAMT_W-salc_pkg::BLOCK_BITS_W){1'b0}}, b_eff};
    assign in_tag       = TAG_W'(in_addr >> tag_shamt);

    // ---------------- storage ----------------
    t_tag_row        r_mem_tag  [NUM_SETS];
    t_rank_row       r_mem_rank [NUM_SETS];
    logic [WAYS-1:0] r_line_vld [NUM_SETS];

    // ---------------- lookup stage registers ----------------
    logic                    r_s1_vld;
    logic [MAX_SET_BITS-1:0] r_s1_set;
    logic [TAG_W-1:0]        r_s1_tag;
    logic                    r_s1_fwd;
    t_tag_row                r_rd_tag;
    t_rank_row               r_rd_rank;
    logic [WAYS-1:0]         r_rd_vld;
    t_tag_row                r_fwd_tag;
    t_rank_row               r_fwd_rank;
    logic [WAYS-1:0]         r_fwd_vld;

    // ---------------- output registers ----------------
    logic          r_out_vld;
    logic          r_out_hit;
    logic          r_out_miss;
    logic          r_out_evict;
    logic [TW-1:0] r_hit_cnt;
    logic [TW-1:0] r_miss_cnt;
    logic [TW-1:0] r_evict_cnt;

    // ---------------- handshake ----------------
    logic adv;
    logic in_acc;

    // lookup stage moves into the output register
    assign adv     = r_s1_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_s1_vld && !adv;
    assign in_acc  = i_valid && !o_stall;

    // ---------------- lookup and LRU update ----------------
    t_tag_row        cur_tag;
    t_rank_row       cur_rank;
    logic [WAYS-1:0] cur_vld;
    t_tag_row        n_tag_row;
    t_rank_row       n_rank_row;
    logic [WAYS-1:0] n_vld_row;
    logic            hit;
    logic            has_empty;
    logic            fresh;
    logic [WAY_W-1:0] found_w;
    logic [WAY_W-1:0] empty_w;
    logic [WAY_W-1:0] victim_w;
    logic [WAY_W-1:0] sel_w;
    logic [RANK_W-1:0] best_rank;
    logic [RANK_W-1:0] old_rank;

    always_comb begin
        // same-set item just ahead wrote this row; take its copy
        cur_tag  = r_s1_fwd ? r_fwd_tag  : r_rd_tag;
        cur_rank = r_s1_fwd ? r_fwd_rank : r_rd_rank;
        cur_vld  = r_s1_fwd ? r_fwd_vld  : r_rd_vld;

        hit       = 1'b0;
        has_empty = 1'b0;
        found_w   = '0;
        empty_w   = '0;
        // lowest way wins: scan downward
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (cur_vld[i] && cur_tag[i] == r_s1_tag) begin
                hit     = 1'b1;
                found_w = WAY_W'(i);
            end
            if (!cur_vld[i]) begin
                has_empty = 1'b1;
                empty_w   = WAY_W'(i);
            end
        end

        // oldest line, lowest way on a tie
        victim_w  = '0;
        best_rank = cur_rank[0];
        for (int i = 1; i < WAYS; i++) begin
            if (cur_rank[i] > best_rank) begin
                best_rank = cur_rank[i];
                victim_w  = WAY_W'(i);
            end
        end

        fresh = !hit && has_empty;
        if (hit)
            sel_w = found_w;
        else if (has_empty)
            sel_w = empty_w;
        else
            sel_w = victim_w;
        old_rank = cur_rank[sel_w];

        n_tag_row  = cur_tag;
        n_rank_row = cur_rank;
        n_vld_row  = cur_vld;
        // age the lines that were newer than the touched one (all on a fill)
        for (int i = 0; i < WAYS; i++) begin
            if (WAY_W'(i) != sel_w && cur_vld[i]
                    && (fresh || cur_rank[i] < old_rank)
                    && cur_rank[i] < RANK_W'(WAYS - 1)) begin
                n_rank_row[i] = cur_rank[i] + RANK_W'(1);
            end
        end
        n_rank_row[sel_w] = '0;
        n_vld_row[sel_w]  = 1'b1;
        if (!hit)
            n_tag_row[sel_w] = r_s1_tag;
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= salc_pkg::SET_BITS_RST;
            r_block_bits <= salc_pkg::BLOCK_BITS_RST;
            r_s1_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_hit_cnt    <= '0;
            r_miss_cnt   <= '0;
            r_evict_cnt  <= '0;
            for (int i = 0; i < NUM_SETS; i++)
                r_line_vld[i] <= '0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    salc_pkg::CFG_SET_BITS:
                        r_set_bits <= pwdata[salc_pkg::SET_BITS_W-1:0];
                    salc_pkg::CFG_BLOCK_BITS:
                        r_block_bits <= pwdata[salc_pkg::BLOCK_BITS_W-1:0];
                    default: ;
                endcase
            end

            if (in_acc)
                r_s1_vld <= 1'b1;
            else if (adv)
                r_s1_vld <= 1'b0;

            if (adv)
                r_out_vld <= 1'b1;
            else if (!i_stall)
                r_out_vld <= 1'b0;

            if (adv) begin
                r_hit_cnt   <= r_hit_cnt + {{(TW-1){1'b0}}, hit};
                r_miss_cnt  <= r_miss_cnt + {{(TW-1){1'b0}}, !hit};
                r_evict_cnt <= r_evict_cnt + {{(TW-1){1'b0}}, !hit && !has_empty};
                r_line_vld[r_s1_set] <= n_vld_row;
            end
        end
    end

    // ---------------- memories and payload ----------------
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mem_tag[r_s1_set]  <= n_tag_row;
            r_mem_rank[r_s1_set] <= n_rank_row;
            r_out_hit   <= hit;
            r_out_miss  <= !hit;
            r_out_evict <= !hit && !has_empty;
        end
        if (in_acc) begin
            r_rd_tag   <= r_mem_tag[in_set];
            r_rd_rank  <= r_mem_rank[in_set];
            r_rd_vld   <= r_line_vld[in_set];
            r_s1_fwd   <= adv && (r_s1_set == in_set);
            r_fwd_tag  <= n_tag_row;
            r_fwd_rank <= n_rank_row;
            r_fwd_vld  <= n_vld_row;
            r_s1_set   <= in_set;
            r_s1_tag   <= in_tag;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_hit         = r_out_hit;
    assign o_miss        = r_out_miss;
    assign o_evicted     = r_out_evict;
    assign o_hit_total   = r_hit_cnt;
    assign o_miss_total  = r_miss_cnt;
    assign o_evict_total = r_evict_cnt;

endmodule
